[hw/rtl/fcrl_pkg.sv]
// Package for the fixed-capacity record list: sizes, item and record types,
// command codes, and the control/status structs shared by ctrl and datapath.
// No dependencies.
package fcrl_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1;

  typedef enum logic [3:0] {
    CMD_INS_HEAD = 4'd0,
    CMD_INS_TAIL = 4'd1,
    CMD_INS_SORT = 4'd2,
    CMD_RM_HEAD  = 4'd3,
    CMD_RM_TAIL  = 4'd4,
    CMD_RM_SHIFT = 4'd5,
    CMD_RM_SWAP  = 4'd6,
    CMD_READ     = 4'd7,
    CMD_FIND     = 4'd8
  } cmd_e;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] entry_key;
    logic [31:0]        entry_word_a;
    logic [31:0]        entry_word_b;
    logic [31:0]        entry_word_c;
    logic [4:0]         position;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] found_key;
    logic [31:0]        found_word_a;
    logic [31:0]        found_word_b;
    logic [31:0]        found_word_c;
    logic [CntW-1:0]    fill_count;
    logic               is_full;
    logic               is_empty;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [31:0]        wa;
    logic [31:0]        wb;
    logic [31:0]        wc;
  } rec_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_COUNT,
    PTR_POS,
    PTR_INC
  } ptr_op_e;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_NEXT,
    RD_LAST
  } rd_sel_e;

  typedef enum logic {
    WR_CARRY,
    WR_READ
  } wr_src_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_LT,
    ST_SCAN_EQ,
    ST_INSERT,
    ST_CLOSE,
    ST_SWAP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic    load;
    ptr_op_e ptr_op;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_src_e wr_src;
    logic    carry_ld;
    cnt_op_e cnt_op;
    logic    res_ld;
    logic    res_ok;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic ptr_lt_cnt;
    logic ptr_eq_cnt;
    logic next_lt_cnt;
    logic key_lt;
    logic key_eq;
    logic pos_ok;
  } dp_stat_t;

endpackage

[hw/rtl/fixed_capacity_record_list.sv]
// Top level of the fixed-capacity record list: joins fcrl_ctrl and fcrl_dpath.
// Depends on fcrl_pkg, fcrl_ctrl, fcrl_dpath.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_item_i carries one command item;
//   it is taken at a clock edge with in_valid_i high and in_stall_o low.
//   Output channel out_valid_o / out_stall_i / out_item_o returns exactly one
//   result item per command, taken when out_valid_o is high and out_stall_i low.
//   One command is in work at a time; in_stall_o is low only while idle.
//   Head insert, head removal, sorted insert, keyed removal and find walk the
//   record array, one entry per cycle through its single read port; tail
//   insert writes one entry, and tail removal, reads, unknown codes and
//   commands refused on a full or empty list do not walk it.
//   A finished result waits in the output register while the receiver stalls;
//   the next command is still accepted, and its result is held back until the
//   previous one is taken.
//   Reset empties the list (fill count zero) and clears the output valid; record
//   contents are not cleared and need no clearing pass.
module fixed_capacity_record_list (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fcrl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fcrl_pkg::out_item_t out_item_o
);
  import fcrl_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  fcrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_stat_i   (dp_stat),
    .dp_cmd_o    (dp_cmd)
  );

  fcrl_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .dp_cmd_i   (dp_cmd),
    .dp_stat_o  (dp_stat),
    .out_item_o (out_item_o)
  );

  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("input not stalled after accepting an item");

  a_count_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_item_o.fill_count) <= Capacity)
  ) else $error("fill count beyond capacity");

  a_flags_match_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.is_empty == (out_item_o.fill_count == '0))
                     && !(out_item_o.is_full && out_item_o.is_empty))
  ) else $error("full/empty flags disagree with fill count");

  a_fail_no_record: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.ok) |-> (out_item_o.found_key == '0
      && out_item_o.found_word_a == '0 && out_item_o.found_word_b == '0
      && out_item_o.found_word_c == '0)
  ) else $error("failed command returned record data");

endmodule

[hw/rtl/fcrl_dpath.sv]
// Datapath of the record list: record array, pointer, fill count, carry
// register, captured item and result register. Driven by fcrl_ctrl.
// Depends on fcrl_pkg.
module fcrl_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fcrl_pkg::in_item_t in_item_i,
  input  fcrl_pkg::dp_cmd_t  dp_cmd_i,
  output fcrl_pkg::dp_stat_t dp_stat_o,
  output fcrl_pkg::out_item_t out_item_o
);
  import fcrl_pkg::*;

  in_item_t        item_q;
  rec_t            carry_q;
  rec_t            store_q [Capacity];
  rec_t            rd_rec;
  rec_t            res_rec;
  out_item_t       res_q;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_addr;
  logic [CntW-1:0] ptr_next;
  cmd_e            cmd;

  assign cmd      = cmd_e'(item_q.command);
  assign ptr_next = ptr_q + CntW'(1);

  always_comb begin
    unique case (dp_cmd_i.rd_sel)
      RD_PTR:  rd_addr = ptr_q;
      RD_NEXT: rd_addr = ptr_next;
      RD_LAST: rd_addr = count_q - CntW'(1);
      default: rd_addr = ptr_q;
    endcase
  end

  assign rd_rec = store_q[rd_addr[AddrW-1:0]];

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.wr_en) begin
      store_q[ptr_q[AddrW-1:0]] <= (dp_cmd_i.wr_src == WR_CARRY) ? carry_q : rd_rec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      item_q        <= in_item_i;
      carry_q.key   <= in_item_i.entry_key;
      carry_q.wa    <= in_item_i.entry_word_a;
      carry_q.wb    <= in_item_i.entry_word_b;
      carry_q.wc    <= in_item_i.entry_word_c;
    end else if (dp_cmd_i.carry_ld) begin
      carry_q <= rd_rec;
    end
  end

  always_comb begin
    unique case (dp_cmd_i.ptr_op)
      PTR_HOLD:  ptr_d = ptr_q;
      PTR_ZERO:  ptr_d = '0;
      PTR_COUNT: ptr_d = count_q;
      PTR_POS:   ptr_d = CntW'(item_q.position) - CntW'(1);
      PTR_INC:   ptr_d = ptr_next;
      default:   ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    unique case (dp_cmd_i.cnt_op)
      CNT_HOLD: count_d = count_q;
      CNT_INC:  count_d = count_q + CntW'(1);
      CNT_DEC:  count_d = count_q - CntW'(1);
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      count_q <= '0;
    end else begin
      ptr_q   <= ptr_d;
      count_q <= count_d;
    end
  end

  assign res_rec = (dp_cmd_i.res_ok && (cmd == CMD_READ || cmd == CMD_FIND)) ? rd_rec : '0;

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.res_ld) begin
      res_q.ok           <= dp_cmd_i.res_ok;
      res_q.found_key    <= res_rec.key;
      res_q.found_word_a <= res_rec.wa;
      res_q.found_word_b <= res_rec.wb;
      res_q.found_word_c <= res_rec.wc;
      res_q.fill_count   <= count_q;
      res_q.is_full      <= (count_q == CntW'(Capacity));
      res_q.is_empty     <= (count_q == '0);
    end
  end

  assign out_item_o = res_q;

  always_comb begin
    dp_stat_o.cmd         = cmd;
    dp_stat_o.full        = (count_q == CntW'(Capacity));
    dp_stat_o.empty       = (count_q == '0);
    dp_stat_o.ptr_lt_cnt  = (ptr_q < count_q);
    dp_stat_o.ptr_eq_cnt  = (ptr_q == count_q);
    dp_stat_o.next_lt_cnt = (ptr_next < count_q);
    dp_stat_o.key_lt      = (rd_rec.key < item_q.entry_key);
    dp_stat_o.key_eq      = (rd_rec.key == item_q.entry_key);
    dp_stat_o.pos_ok      = (item_q.position != '0)
                            && (32'(item_q.position) <= 32'(count_q));
  end

endmodule

[hw/rtl/fcrl_ctrl.sv]
// Controller of the record list: sequences scan, insert, close and swap walks
// over the record array and owns the input stall and output valid.
// Depends on fcrl_pkg.
module fcrl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  fcrl_pkg::dp_stat_t dp_stat_i,
  output fcrl_pkg::dp_cmd_t  dp_cmd_o
);
  import fcrl_pkg::*;

  state_e state_q, state_d;
  logic   ok_q, ok_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    ok_d              = ok_q;
    out_valid_d       = out_valid_q && out_stall_i;
    dp_cmd_o          = '0;
    dp_cmd_o.ptr_op   = PTR_HOLD;
    dp_cmd_o.rd_sel   = RD_PTR;
    dp_cmd_o.wr_src   = WR_CARRY;
    dp_cmd_o.cnt_op   = CNT_HOLD;
    dp_cmd_o.res_ok   = ok_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dp_cmd_o.load = 1'b1;
          ok_d          = 1'b0;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_DONE;
        unique case (dp_stat_i.cmd)
          CMD_INS_HEAD: begin
            if (!dp_stat_i.full) begin
              dp_cmd_o.ptr_op = PTR_ZERO;
              state_d         = ST_INSERT;
            end
          end
          CMD_INS_TAIL: begin
            if (!dp_stat_i.full) begin
              dp_cmd_o.ptr_op = PTR_COUNT;
              state_d         = ST_INSERT;
            end
          end
          CMD_INS_SORT: begin
            if (!dp_stat_i.full) begin
              dp_cmd_o.ptr_op = PTR_ZERO;
              state_d         = ST_SCAN_LT;
            end
          end
          CMD_RM_HEAD: begin
            if (!dp_stat_i.empty) begin
              dp_cmd_o.ptr_op = PTR_ZERO;
              state_d         = ST_CLOSE;
            end
          end
          CMD_RM_TAIL: begin
            if (!dp_stat_i.empty) begin
              dp_cmd_o.cnt_op = CNT_DEC;
              ok_d            = 1'b1;
            end
          end
          CMD_RM_SHIFT, CMD_RM_SWAP, CMD_FIND: begin
            dp_cmd_o.ptr_op = PTR_ZERO;
            state_d         = ST_SCAN_EQ;
          end
          CMD_READ: begin
            if (dp_stat_i.pos_ok) begin
              dp_cmd_o.ptr_op = PTR_POS;
              ok_d            = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_SCAN_LT: begin
        if (dp_stat_i.ptr_lt_cnt && dp_stat_i.key_lt) begin
          dp_cmd_o.ptr_op = PTR_INC;
        end else begin
          state_d = ST_INSERT;
        end
      end
      ST_SCAN_EQ: begin
        priority if (!dp_stat_i.ptr_lt_cnt) begin
          state_d = ST_DONE;
        end else if (dp_stat_i.key_eq) begin
          if (dp_stat_i.cmd == CMD_RM_SHIFT) begin
            state_d = ST_CLOSE;
          end else if (dp_stat_i.cmd == CMD_RM_SWAP) begin
            state_d = ST_SWAP;
          end else begin
            ok_d    = 1'b1;
            state_d = ST_DONE;
          end
        end else begin
          dp_cmd_o.ptr_op = PTR_INC;
        end
      end
      ST_INSERT: begin
        dp_cmd_o.wr_en    = 1'b1;
        dp_cmd_o.wr_src   = WR_CARRY;
        dp_cmd_o.carry_ld = 1'b1;
        if (dp_stat_i.ptr_eq_cnt) begin
          dp_cmd_o.cnt_op = CNT_INC;
          ok_d            = 1'b1;
          state_d         = ST_DONE;
        end else begin
          dp_cmd_o.ptr_op = PTR_INC;
        end
      end
      ST_CLOSE: begin
        dp_cmd_o.rd_sel = RD_NEXT;
        if (dp_stat_i.next_lt_cnt) begin
          dp_cmd_o.wr_en  = 1'b1;
          dp_cmd_o.wr_src = WR_READ;
          dp_cmd_o.ptr_op = PTR_INC;
        end else begin
          dp_cmd_o.cnt_op = CNT_DEC;
          ok_d            = 1'b1;
          state_d         = ST_DONE;
        end
      end
      ST_SWAP: begin
        dp_cmd_o.rd_sel = RD_LAST;
        dp_cmd_o.wr_en  = 1'b1;
        dp_cmd_o.wr_src = WR_READ;
        dp_cmd_o.cnt_op = CNT_DEC;
        ok_d            = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          dp_cmd_o.res_ld = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[bench/fixed_capacity_record_list_tb.sv]
// Self-checking bench for fixed_capacity_record_list: a shadow record list predicts
// each result, and the driver and monitor run with random bursts, gaps and stalls.
// Depends on fcrl_pkg and the fixed_capacity_record_list RTL.
module fixed_capacity_record_list_tb;
  import fcrl_pkg::*;

  localparam int          NumRandom    = 426;
  localparam int          CycleLimit   = 200000;
  localparam int          MaxShown     = 10;
  localparam logic [3:0]  CmdUnknownLo = 4'd9;
  localparam logic [3:0]  CmdUnknownHi = 4'd15;
  localparam int          PhaseFill    = 0;
  localparam int          PhaseDrain   = 1;
  localparam int          PhaseMixed   = 2;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  fixed_capacity_record_list dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // shadow copy of the list
  rec_t      shadow_recs [Capacity];
  int        shadow_count = 0;

  in_item_t  pending_cmds [$];
  bit        wait_drain_q [$];
  out_item_t expected_results [$];

  int        burst_left   = 0;
  int        gap_left     = 0;
  int        stall_run    = 0;
  int        stall_mode   = 0;
  int        cycle_count  = 0;
  int        mismatches   = 0;
  int        cmds_taken   = 0;
  int        results_seen = 0;
  int        ok_count     = 0;
  int        full_hits    = 0;
  int        empty_hits   = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int slot_of_key(input logic signed [31:0] key);
    int i;
    i = 0;
    while (i < shadow_count && shadow_recs[i].key != key) i++;
    return i;
  endfunction

  function automatic out_item_t list_apply(input in_item_t it);
    out_item_t res;
    rec_t      nrec;
    int        at;
    int        k;
    res       = '0;
    nrec.key  = it.entry_key;
    nrec.wa   = it.entry_word_a;
    nrec.wb   = it.entry_word_b;
    nrec.wc   = it.entry_word_c;
    case (it.command)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_SORT: begin
        if (shadow_count < Capacity) begin
          if (it.command == CMD_INS_HEAD) begin
            at = 0;
          end else if (it.command == CMD_INS_TAIL) begin
            at = shadow_count;
          end else begin
            at = 0;
            while (at < shadow_count &&
                   $signed(shadow_recs[at].key) < $signed(nrec.key)) at++;
          end
          for (k = shadow_count; k > at; k--) shadow_recs[k] = shadow_recs[k-1];
          shadow_recs[at] = nrec;
          shadow_count++;
          res.ok = 1'b1;
        end
      end
      CMD_RM_HEAD: begin
        if (shadow_count > 0) begin
          for (k = 0; k + 1 < shadow_count; k++) shadow_recs[k] = shadow_recs[k+1];
          shadow_count--;
          res.ok = 1'b1;
        end
      end
      CMD_RM_TAIL: begin
        if (shadow_count > 0) begin
          shadow_count--;
          res.ok = 1'b1;
        end
      end
      CMD_RM_SHIFT, CMD_RM_SWAP: begin
        at = slot_of_key(it.entry_key);
        if (at < shadow_count) begin
          if (it.command == CMD_RM_SHIFT) begin
            for (k = at; k + 1 < shadow_count; k++) shadow_recs[k] = shadow_recs[k+1];
            shadow_count--;
          end else begin
            shadow_count--;
            shadow_recs[at] = shadow_recs[shadow_count];
          end
          res.ok = 1'b1;
        end
      end
      CMD_READ: begin
        if (it.position >= 1 && it.position <= shadow_count) begin
          nrec   = shadow_recs[it.position - 1];
          res.ok = 1'b1;
          res.found_key    = nrec.key;
          res.found_word_a = nrec.wa;
          res.found_word_b = nrec.wb;
          res.found_word_c = nrec.wc;
        end
      end
      CMD_FIND: begin
        at = slot_of_key(it.entry_key);
        if (at < shadow_count) begin
          nrec   = shadow_recs[at];
          res.ok = 1'b1;
          res.found_key    = nrec.key;
          res.found_word_a = nrec.wa;
          res.found_word_b = nrec.wb;
          res.found_word_c = nrec.wc;
        end
      end
      default: begin
      end
    endcase
    res.fill_count = shadow_count[CntW-1:0];
    res.is_full    = (shadow_count == Capacity);
    res.is_empty   = (shadow_count == 0);
    return res;
  endfunction

  function automatic in_item_t make_cmd(input logic [3:0] cmd, input logic [31:0] key,
                                        input logic [4:0] pos);
    in_item_t it;
    it.command      = cmd;
    it.entry_key    = key;
    it.entry_word_a = $urandom();
    it.entry_word_b = $urandom();
    it.entry_word_c = $urandom();
    it.position     = pos;
    return it;
  endfunction

  // small key pool so finds and keyed removals hit, with duplicates and extremes
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'd0;
      4:       return 32'd1;
      5:       return 32'd42;
      6:       return 32'hffff_fff9;
      7:       return 32'd1000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [3:0] pick_cmd(input int phase);
    int roll;
    int ins_cut;
    int rm_cut;
    roll = $urandom_range(0, 99);
    case (phase)
      PhaseFill:  begin ins_cut = 85; rm_cut = 93; end
      PhaseDrain: begin ins_cut = 15; rm_cut = 85; end
      default:    begin ins_cut = 30; rm_cut = 55; end
    endcase
    if (roll < 2) return 4'($urandom_range(CmdUnknownLo, CmdUnknownHi));
    if (roll < ins_cut) begin
      case ($urandom_range(0, 3))
        0:       return CMD_INS_HEAD;
        1:       return CMD_INS_TAIL;
        default: return CMD_INS_SORT;
      endcase
    end
    if (roll < rm_cut) begin
      case ($urandom_range(0, 3))
        0:       return CMD_RM_HEAD;
        1:       return CMD_RM_TAIL;
        2:       return CMD_RM_SHIFT;
        default: return CMD_RM_SWAP;
      endcase
    end
    return ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_FIND;
  endfunction

  task automatic queue_cmd(input in_item_t it, input bit drain_first);
    pending_cmds.push_back(it);
    wait_drain_q.push_back(drain_first);
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MaxShown)
        $display("result %0d: %s expected %h, got %h", results_seen, fname, want, got);
    end
  endtask

  // driver: bursts of items with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    bit next_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      next_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(list_apply(in_item_i));
        cmds_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0 &&
                     !(wait_drain_q[0] && expected_results.size() > 0)) begin
          in_item_i <= pending_cmds.pop_front();
          void'(wait_drain_q.pop_front());
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left = 0;
              4, 5, 6, 7: gap_left = $urandom_range(1, 4);
              8:          gap_left = $urandom_range(5, 15);
              default: begin
                gap_left   = 0;
                burst_left = $urandom_range(40, 80);
              end
            endcase
          end
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // monitor: check each result and stall on a pattern of its own
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    bit        next_stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("result %0d: none expected, got %p", results_seen, out_item_o);
        end else begin
          want = expected_results.pop_front();
          check_field("ok",           want.ok,           out_item_o.ok);
          check_field("found_key",    want.found_key,    out_item_o.found_key);
          check_field("found_word_a", want.found_word_a, out_item_o.found_word_a);
          check_field("found_word_b", want.found_word_b, out_item_o.found_word_b);
          check_field("found_word_c", want.found_word_c, out_item_o.found_word_c);
          check_field("fill_count",   want.fill_count,   out_item_o.fill_count);
          check_field("is_full",      want.is_full,      out_item_o.is_full);
          check_field("is_empty",     want.is_empty,     out_item_o.is_empty);
          ok_count   += want.ok;
          full_hits  += want.is_full;
          empty_hits += want.is_empty;
        end
      end
      if (cycle_count % 256 == 0) stall_mode = $urandom_range(0, 2);
      if (stall_run > 0) begin
        stall_run--;
        next_stall = 1'b1;
      end else if (stall_mode == 1) begin
        next_stall = ($urandom_range(0, 3) == 0);
      end else if (stall_mode == 2 && $urandom_range(0, 7) == 0) begin
        stall_run  = $urandom_range(5, 25);
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
      out_stall_i <= next_stall;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("fixed_capacity_record_list test failed");
      $finish;
    end
  end

  initial begin
    int made;
    int phase;
    int len;
    int n;

    // empty list: every removal, read and find fails
    queue_cmd(make_cmd(CMD_RM_HEAD,  32'd0, 5'd0), 1'b0);
    queue_cmd(make_cmd(CMD_RM_TAIL,  32'd0, 5'd0), 1'b0);
    queue_cmd(make_cmd(CMD_RM_SHIFT, 32'd0, 5'd0), 1'b0);
    queue_cmd(make_cmd(CMD_RM_SWAP,  32'd0, 5'd0), 1'b0);
    queue_cmd(make_cmd(CMD_READ,     32'd0, 5'd1), 1'b0);
    queue_cmd(make_cmd(CMD_FIND,     32'd0, 5'd0), 1'b0);
    queue_cmd(make_cmd(CmdUnknownHi, 32'hffff_ffff, 5'd16), 1'b0);
    // extreme keys and payloads, equal keys in sorted insert, then reads, finds and removals
    queue_cmd('{CMD_INS_HEAD, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 5'd16}, 1'b0);
    queue_cmd('{CMD_INS_TAIL, 32'h7fff_ffff, 32'd0, 32'd0, 32'd0, 5'd0}, 1'b0);
    queue_cmd(make_cmd(CMD_INS_SORT, 32'd0,        5'd0), 1'b0);
    queue_cmd(make_cmd(CMD_INS_SORT, 32'h8000_0000, 5'd0), 1'b0);
    queue_cmd(make_cmd(CMD_INS_SORT, 32'h7fff_ffff, 5'd0), 1'b0);
    queue_cmd(make_cmd(CMD_READ, 32'd0, 5'd0),  1'b0);
    queue_cmd(make_cmd(CMD_READ, 32'd0, 5'd1),  1'b0);
    queue_cmd(make_cmd(CMD_READ, 32'd0, 5'd5),  1'b0);
    queue_cmd(make_cmd(CMD_READ, 32'd0, 5'd16), 1'b0);
    queue_cmd(make_cmd(CMD_FIND, 32'h7fff_ffff, 5'd0), 1'b0);
    queue_cmd(make_cmd(CMD_FIND, 32'd12345,     5'd0), 1'b0);
    queue_cmd(make_cmd(CMD_RM_SHIFT, 32'h8000_0000, 5'd0), 1'b0);
    queue_cmd(make_cmd(CMD_RM_SWAP,  32'd0,         5'd0), 1'b0);
    queue_cmd(make_cmd(CMD_RM_SHIFT, 32'd777,       5'd0), 1'b0);
    queue_cmd(make_cmd(CMD_RM_TAIL,  32'd0,         5'd0), 1'b0);
    queue_cmd(make_cmd(CmdUnknownLo, 32'd0,         5'd3), 1'b0);
    queue_cmd(make_cmd(CMD_RM_HEAD,  32'd0,         5'd0), 1'b0);

    // random phases that fill, drain and mix
    made = 0;
    while (made < NumRandom) begin
      phase = $urandom_range(PhaseFill, PhaseMixed);
      len   = $urandom_range(10, 40);
      if (len > NumRandom - made) len = NumRandom - made;
      for (n = 0; n < len; n++) begin
        queue_cmd(make_cmd(pick_cmd(phase), pick_key(), 5'($urandom_range(0, 16))),
                  (made == 0) || (n == 0 && $urandom_range(0, 4) == 0));
        made++;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("%0d commands taken, %0d results checked, %0d succeeded",
             cmds_taken, results_seen, ok_count);
    $display("list was full after %0d commands and empty after %0d, %0d mismatches",
             full_hits, empty_hits, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("fixed_capacity_record_list test passed");
    end else begin
      $display("fixed_capacity_record_list test failed");
    end
    $finish;
  end

endmodule
